// ----- hw/rtl/iltd_pkg.sv -----
// Shared types and constants for the ID/length-table packet deframer.
// Used by iltd_ctrl, iltd_dpath and id_length_table_packet_deframer.
`default_nettype none

package iltd_pkg;

  localparam logic [7:0] ID_RESERVED = 8'hFF;

  // Result status codes.
  localparam logic [2:0] STS_REGISTERED = 3'd0;
  localparam logic [2:0] STS_REJECTED   = 3'd1;
  localparam logic [2:0] STS_HEADER     = 3'd2;
  localparam logic [2:0] STS_PAYLOAD    = 3'd3;
  localparam logic [2:0] STS_UNKNOWN    = 3'd4;
  localparam logic [2:0] STS_DISCARDED  = 3'd5;

  // Input item commands.
  localparam logic CMD_DATA     = 1'b0;
  localparam logic CMD_REGISTER = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data_byte;
    logic        chunk_end;
    logic [7:0]  entry_id;
    logic [15:0] entry_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] packet_id;
    logic [3:0] matched_index;
    logic [7:0] payload_byte;
    logic [9:0] byte_index;
    logic [9:0] payload_len;
    logic       last;
  } out_item_t;

  // Controller to datapath: load the result register and apply the
  // state update that belongs to the chosen status.
  typedef struct packed {
    logic       load;
    logic [2:0] code;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;       // header byte matches a registered entry
    logic reg_ok;    // register item may be appended
    logic hdr_zero;  // matched entry has zero payload length
    logic pay_done;  // current payload byte is the packet's last
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/iltd_dpath.sv -----
// Datapath: ID/size tables, lookup, packet counters and result register.
// Depends on iltd_pkg; driven by commands from iltd_ctrl.
`default_nettype none

module iltd_dpath import iltd_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int MAX_PAYLOAD = 1023
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   item,
  input  wire dp_cmd_t    cmd,
  output      dp_status_t sts,
  output      out_item_t  result
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]    id_table   [TABLE_DEPTH];
  logic [LW-1:0] size_table [TABLE_DEPTH];

  logic [CW-1:0] entry_count_r,    entry_count_nxt;
  logic [7:0]    current_id_r,     current_id_nxt;
  logic [IW-1:0] current_index_r,  current_index_nxt;
  logic [LW-1:0] expected_len_r,   expected_len_nxt;
  logic [LW-1:0] received_count_r, received_count_nxt;
  out_item_t     result_r,         result_nxt;

  logic [TABLE_DEPTH-1:0] match;
  logic [IW-1:0]          hit_slot;
  logic [LW-1:0]          slot_len;
  logic [LW:0]            next_pos;

  // Parallel compare against every filled entry; the lowest index wins.
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (CW'(i) < entry_count_r) && (id_table[i] == item.data_byte);
    end
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = IW'(i);
      end
    end
  end

  assign slot_len = size_table[hit_slot];
  assign next_pos = {1'b0, received_count_r} + (LW+1)'(1);

  assign sts.hit      = |match;
  assign sts.reg_ok   = (item.entry_id != ID_RESERVED) &&
                        (entry_count_r < CW'(TABLE_DEPTH)) &&
                        (item.entry_size <= 16'(MAX_PAYLOAD));
  assign sts.hdr_zero = (slot_len == '0);
  assign sts.pay_done = (next_pos >= {1'b0, expected_len_r});

  always_comb begin
    entry_count_nxt    = entry_count_r;
    current_id_nxt     = current_id_r;
    current_index_nxt  = current_index_r;
    expected_len_nxt   = expected_len_r;
    received_count_nxt = received_count_r;
    result_nxt         = '0;
    result_nxt.status  = cmd.code;
    case (cmd.code)
      STS_REGISTERED: begin
        entry_count_nxt          = entry_count_r + CW'(1);
        result_nxt.packet_id     = item.entry_id;
        result_nxt.matched_index = 4'(entry_count_r);
        result_nxt.payload_len   = item.entry_size[9:0];
      end
      STS_REJECTED: begin
        result_nxt.packet_id = item.entry_id;
      end
      STS_HEADER: begin
        current_id_nxt           = item.data_byte;
        current_index_nxt        = hit_slot;
        expected_len_nxt         = slot_len;
        received_count_nxt       = '0;
        result_nxt.packet_id     = item.data_byte;
        result_nxt.matched_index = 4'(hit_slot);
        result_nxt.payload_len   = 10'(slot_len);
        result_nxt.last          = sts.hdr_zero;
      end
      STS_PAYLOAD: begin
        received_count_nxt       = sts.pay_done ? '0 : next_pos[LW-1:0];
        result_nxt.packet_id     = current_id_r;
        result_nxt.matched_index = 4'(current_index_r);
        result_nxt.payload_byte  = item.data_byte;
        result_nxt.byte_index    = 10'(received_count_r);
        result_nxt.payload_len   = 10'(expected_len_r);
        result_nxt.last          = sts.pay_done;
      end
      STS_UNKNOWN: begin
        result_nxt.packet_id = item.data_byte;
      end
      default: begin
        result_nxt.status = cmd.code;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r    <= '0;
      current_id_r     <= ID_RESERVED;
      current_index_r  <= '0;
      expected_len_r   <= '0;
      received_count_r <= '0;
    end else if (cmd.load) begin
      entry_count_r    <= entry_count_nxt;
      current_id_r     <= current_id_nxt;
      current_index_r  <= current_index_nxt;
      expected_len_r   <= expected_len_nxt;
      received_count_r <= received_count_nxt;
    end
  end

  // Tables hold no reset; only entries below the fill count are looked at.
  always_ff @(posedge clk) begin
    if (cmd.load && (cmd.code == STS_REGISTERED)) begin
      id_table[entry_count_r[IW-1:0]]   <= item.entry_id;
      size_table[entry_count_r[IW-1:0]] <= item.entry_size[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

`default_nettype wire

// ----- hw/rtl/iltd_ctrl.sv -----
// Controller: framing state machine and result handshake.
// Depends on iltd_pkg; commands iltd_dpath.
`default_nettype none

module iltd_ctrl import iltd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       item_cmd,
  input  wire logic       chunk_end,
  input  wire logic       out_stall,
  input  wire dp_status_t sts,
  output      logic       in_stall,
  output      logic       out_valid,
  output      dp_cmd_t    cmd
);

  localparam logic [1:0] S_HEADER  = 2'd0;
  localparam logic [1:0] S_PAYLOAD = 2'd1;
  localparam logic [1:0] S_DISCARD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  // A new beat is taken whenever the result register is empty or draining.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = accept;
    cmd.code  = STS_DISCARDED;
    if (item_cmd == CMD_REGISTER) begin
      cmd.code = sts.reg_ok ? STS_REGISTERED : STS_REJECTED;
    end else begin
      case (state_r)
        S_DISCARD: begin
          cmd.code = STS_DISCARDED;
          if (chunk_end) begin
            state_nxt = S_HEADER;
          end
        end
        S_PAYLOAD: begin
          cmd.code = STS_PAYLOAD;
          if (sts.pay_done) begin
            state_nxt = S_HEADER;
          end
        end
        default: begin
          if (sts.hit) begin
            cmd.code = STS_HEADER;
            if (!sts.hdr_zero) begin
              state_nxt = S_PAYLOAD;
            end
          end else begin
            cmd.code = STS_UNKNOWN;
            if (!chunk_end) begin
              state_nxt = S_DISCARD;
            end
          end
        end
      endcase
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HEADER;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        state_r <= state_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- hw/rtl/id_length_table_packet_deframer.sv -----
// Output: a result beat is registered and valid in the cycle after its input beat is taken.
// Throughput: one input beat per cycle unless out_stall holds a valid result;
// the result register refills in the cycle it is drained, and the ID lookup is
// one parallel compare of the table. Reset (rst_n low, synchronous): table
// emptied, framer awaits a header, result register empty.
`default_nettype none

module id_length_table_packet_deframer import iltd_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int MAX_PAYLOAD = 1023
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_item_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  iltd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .item_cmd  (in_data.cmd),
    .chunk_end (in_data.chunk_end),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  iltd_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (in_data),
    .cmd    (cmd),
    .sts    (sts),
    .result (out_data)
  );

endmodule

`default_nettype wire
